// ===== src/yaw_rate_predictive_controller_top_defines.svh =====
// Assertion macros for the yaw rate predictive controller.
`ifndef YAW_RATE_PREDICTIVE_CONTROLLER_TOP_DEFINES_SVH
`define YAW_RATE_PREDICTIVE_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication
`define YRPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define YRPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/yrpc_pkg.sv =====
// Shared types, constants and saturation helper for the yaw rate controller.
package yrpc_pkg;

	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_REF_GAIN      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_FILTER_IN = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FF_GAIN       = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODEL_IN_GAIN = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN      = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRED_SCALE    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PRED_FAST_IN  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PRED_DELAY_IN = 4'd7;

	localparam int DELAY_TAPS_DEF = 6;
	localparam logic signed [15:0] REF_POLE_DEF        = 16'sd3686;
	localparam logic signed [15:0] MODEL_POLE_DEF      = 16'sd3686;
	localparam logic signed [15:0] PRED_FAST_POLE_DEF  = 16'sd3686;
	localparam logic signed [15:0] PRED_DELAY_POLE_DEF = 16'sd3686;

	localparam logic signed [31:0] INT_LIMIT = 32'sd5120;
	localparam logic signed [31:0] OUT_LIMIT = 32'sd25600;

	typedef struct packed {
		logic signed [15:0] ref_gain;
		logic signed [15:0] ref_filter_in;
		logic signed [15:0] ff_gain;
		logic signed [15:0] model_in_gain;
		logic signed [15:0] int_gain;
		logic signed [15:0] pred_scale;
		logic signed [15:0] pred_fast_in;
		logic signed [15:0] pred_delay_in;
	} gains_t;

	typedef struct packed {
		logic               issue;
		logic signed [31:0] a;
		logic signed [15:0] g;
		logic signed [32:0] addend;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic commit;
	} core_status_t;

	function automatic logic signed [31:0] sat_to32(input logic signed [35:0] v);
		if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111)
			sat_to32 = v[31:0];
		else if (v[35])
			sat_to32 = 32'sh8000_0000;
		else
			sat_to32 = 32'sh7FFF_FFFF;
	endfunction

endpackage

// ===== src/yrpc_alu.sv =====
// Shared multiply unit: Q24.8 x Q4.12 product, floor shift, saturate, add, saturate.
module yrpc_alu (
	input  logic               clk,
	input  yrpc_pkg::alu_req_t req,
	output logic signed [31:0] res
);
	import yrpc_pkg::*;

	logic signed [47:0] prod_s1;
	logic signed [32:0] add_s1;
	logic signed [31:0] prod_sat;
	logic signed [35:0] sum;

	always_ff @(posedge clk) begin
		if (req.issue) begin
			prod_s1 <= 48'(req.a) * 48'(req.g);
			add_s1  <= req.addend;
		end
	end

	// dropping the low 12 bits of a two's complement product floors it
	always_comb begin
		prod_sat = sat_to32(prod_s1[47:12]);
		sum      = 36'(prod_sat) + 36'(add_s1);
		res      = sat_to32(sum);
	end

endmodule

// ===== src/yrpc_core.sv =====
// Sequencer and loop state: twelve multiply-accumulate steps per tick on the shared unit.
module yrpc_core #(
	parameter int                 DELAY_TAPS      = yrpc_pkg::DELAY_TAPS_DEF,
	parameter logic signed [15:0] REF_POLE        = yrpc_pkg::REF_POLE_DEF,
	parameter logic signed [15:0] MODEL_POLE      = yrpc_pkg::MODEL_POLE_DEF,
	parameter logic signed [15:0] PRED_FAST_POLE  = yrpc_pkg::PRED_FAST_POLE_DEF,
	parameter logic signed [15:0] PRED_DELAY_POLE = yrpc_pkg::PRED_DELAY_POLE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [15:0]     yaw,
	input  logic signed [15:0]     cmd,
	input  yrpc_pkg::gains_t       gains,
	input  logic                   out_free,
	output yrpc_pkg::core_status_t status,
	output logic signed [15:0]     turn
);
	import yrpc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WB} state_t;

	typedef enum logic [3:0] {
		OP_R, OP_RF_IN, OP_RF_POLE, OP_FF, OP_MDL_IN, OP_MDL_POLE,
		OP_INT, OP_PRED_IN, OP_PF_IN, OP_PF_POLE, OP_PD_IN, OP_PD_POLE
	} op_t;

	state_t state_q;
	op_t    op_q;

	logic signed [15:0] yaw_q, cmd_q, turn_q;
	logic signed [31:0] rfs_q, model_q, integ_q, pfs_q, pds_q, pop_q;
	logic signed [31:0] r_q, tmp_q, ff_q, err_q, intout_q, pin_q;
	logic signed [31:0] ref_hist_q  [DELAY_TAPS];
	logic signed [31:0] pred_hist_q [DELAY_TAPS];

	alu_req_t           req;
	logic signed [31:0] res;
	logic signed [31:0] err_next, pop_next, turn_next;
	logic               commit;

	function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
	                                               input logic signed [31:0] lim);
		if (v > lim)
			clamp32 = lim;
		else if (v < -lim)
			clamp32 = -lim;
		else
			clamp32 = v;
	endfunction

	yrpc_alu u_alu (
		.clk (clk),
		.req (req),
		.res (res)
	);

	always_comb begin
		req.issue  = (state_q == ST_ISSUE);
		req.a      = '0;
		req.g      = '0;
		req.addend = '0;
		case (op_q)
			OP_R: begin
				req.a      = -(32'(cmd_q));
				req.g      = gains.ref_gain;
				req.addend = -(33'(rfs_q));
			end
			OP_RF_IN: begin
				req.a = r_q;
				req.g = gains.ref_filter_in;
			end
			OP_RF_POLE: begin
				req.a      = rfs_q;
				req.g      = REF_POLE;
				req.addend = 33'(tmp_q);
			end
			OP_FF: begin
				req.a = r_q;
				req.g = gains.ff_gain;
			end
			OP_MDL_IN: begin
				req.a = ref_hist_q[DELAY_TAPS-1];
				req.g = gains.model_in_gain;
			end
			OP_MDL_POLE: begin
				req.a      = model_q;
				req.g      = MODEL_POLE;
				req.addend = 33'(tmp_q);
			end
			OP_INT: begin
				req.a      = err_q;
				req.g      = gains.int_gain;
				req.addend = 33'(integ_q);
			end
			OP_PRED_IN: begin
				req.a = intout_q;
				req.g = gains.pred_scale;
			end
			OP_PF_IN: begin
				req.a = pin_q;
				req.g = gains.pred_fast_in;
			end
			OP_PF_POLE: begin
				req.a      = pfs_q;
				req.g      = PRED_FAST_POLE;
				req.addend = 33'(tmp_q);
			end
			OP_PD_IN: begin
				req.a = pred_hist_q[DELAY_TAPS-1];
				req.g = gains.pred_delay_in;
			end
			OP_PD_POLE: begin
				req.a      = pds_q;
				req.g      = PRED_DELAY_POLE;
				req.addend = 33'(tmp_q);
			end
			default: begin
				req.a = '0;
			end
		endcase
	end

	// model_q and pop_q still hold last tick's values when these are used
	always_comb begin
		err_next  = sat_to32(36'(model_q) + 36'(yaw_q) - 36'(pop_q));
		pop_next  = sat_to32(36'(pfs_q) - 36'(pds_q));
		turn_next = clamp32(sat_to32(36'(ff_q) + 36'(intout_q)), OUT_LIMIT);
	end

	assign commit = (state_q == ST_WB) && (op_q == OP_PD_POLE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= OP_R;
			yaw_q    <= '0;
			cmd_q    <= '0;
			turn_q   <= '0;
			rfs_q    <= '0;
			model_q  <= '0;
			integ_q  <= '0;
			pfs_q    <= '0;
			pds_q    <= '0;
			pop_q    <= '0;
			r_q      <= '0;
			tmp_q    <= '0;
			ff_q     <= '0;
			err_q    <= '0;
			intout_q <= '0;
			pin_q    <= '0;
			for (int i = 0; i < DELAY_TAPS; i++) begin
				ref_hist_q[i]  <= '0;
				pred_hist_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						yaw_q   <= yaw;
						cmd_q   <= cmd;
						op_q    <= OP_R;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					case (op_q)
						OP_R:       r_q   <= res;
						OP_RF_IN:   tmp_q <= res;
						OP_RF_POLE: rfs_q <= res;
						OP_FF:      ff_q  <= res;
						OP_MDL_IN: begin
							tmp_q <= res;
							for (int i = DELAY_TAPS - 1; i > 0; i--)
								ref_hist_q[i] <= ref_hist_q[i-1];
							ref_hist_q[0] <= r_q;
						end
						OP_MDL_POLE: begin
							err_q    <= err_next;
							intout_q <= integ_q;
							model_q  <= res;
						end
						OP_INT: integ_q <= clamp32(res, INT_LIMIT);
						OP_PRED_IN: begin
							pin_q <= res;
							pop_q <= pop_next;
						end
						OP_PF_IN:   tmp_q <= res;
						OP_PF_POLE: pfs_q <= res;
						OP_PD_IN: begin
							tmp_q <= res;
							for (int i = DELAY_TAPS - 1; i > 0; i--)
								pred_hist_q[i] <= pred_hist_q[i-1];
							pred_hist_q[0] <= pin_q;
						end
						OP_PD_POLE: begin
							// hold here until the output register can take the beat
							if (out_free) begin
								pds_q  <= res;
								turn_q <= turn_next[15:0];
							end
						end
						default: tmp_q <= res;
					endcase
					if (op_q != OP_PD_POLE) begin
						op_q    <= op_t'(op_q + 4'd1);
						state_q <= ST_ISSUE;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign status.busy   = (state_q != ST_IDLE);
	assign status.commit = commit;
	assign turn          = turn_q;

endmodule

// ===== src/yaw_rate_predictive_controller_top.sv =====
// Top level of the yaw rate predictive controller: handshakes, gain registers, output beat.
// One tick of the controller is computed as twelve multiply-accumulate steps on a single
// shared 32x16 multiplier, each step an issue state (operand select and multiply) followed
// by a writeback state (shift, saturate and add back into the loop state). in_stall stays
// high until the result is committed, so inputs are not taken while a tick is running. The
// final step waits while a previous result still sits unread in the output register. Gain
// registers are written through cfg_valid/cfg_ready (ready is always high); the user must
// write them only while the block is idle, which the block itself does not enforce.
// Indexes 8 and above are ignored. All loop state is zero after reset.
module yaw_rate_predictive_controller_top #(
	parameter int                 DELAY_TAPS      = yrpc_pkg::DELAY_TAPS_DEF,
	parameter logic signed [15:0] REF_POLE        = yrpc_pkg::REF_POLE_DEF,
	parameter logic signed [15:0] MODEL_POLE      = yrpc_pkg::MODEL_POLE_DEF,
	parameter logic signed [15:0] PRED_FAST_POLE  = yrpc_pkg::PRED_FAST_POLE_DEF,
	parameter logic signed [15:0] PRED_DELAY_POLE = yrpc_pkg::PRED_DELAY_POLE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [15:0]             yaw_rate,
	input  logic signed [15:0]             yaw_rate_target,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [15:0]             turn_value,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [yrpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);
	import yrpc_pkg::*;

	gains_t       gains_q;
	core_status_t status;
	logic         out_valid_q;
	logic         out_free;
	logic         start;

	assign cfg_ready = 1'b1;
	assign start     = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REF_GAIN:      gains_q.ref_gain      <= cfg_data;
				REG_REF_FILTER_IN: gains_q.ref_filter_in <= cfg_data;
				REG_FF_GAIN:       gains_q.ff_gain       <= cfg_data;
				REG_MODEL_IN_GAIN: gains_q.model_in_gain <= cfg_data;
				REG_INT_GAIN:      gains_q.int_gain      <= cfg_data;
				REG_PRED_SCALE:    gains_q.pred_scale    <= cfg_data;
				REG_PRED_FAST_IN:  gains_q.pred_fast_in  <= cfg_data;
				REG_PRED_DELAY_IN: gains_q.pred_delay_in <= cfg_data;
				default:           gains_q <= gains_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (status.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	yrpc_core #(
		.DELAY_TAPS      (DELAY_TAPS),
		.REF_POLE        (REF_POLE),
		.MODEL_POLE      (MODEL_POLE),
		.PRED_FAST_POLE  (PRED_FAST_POLE),
		.PRED_DELAY_POLE (PRED_DELAY_POLE)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.yaw      (yaw_rate),
		.cmd      (yaw_rate_target),
		.gains    (gains_q),
		.out_free (out_free),
		.status   (status),
		.turn     (turn_value)
	);

	assign in_stall  = status.busy;
	assign out_valid = out_valid_q;

endmodule

// ===== src/yrpc_checker.sv =====
// Port-level checks for the yaw rate predictive controller, bound to the top level.
`include "yaw_rate_predictive_controller_top_defines.svh"

module yrpc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic signed [15:0]             turn_value
);

	`YRPC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(turn_value), "stalled output beat changed")
	`YRPC_ASSERT_SAME(a_out_range, clk, arst_n, out_valid, turn_value <= 16'sd25600 && turn_value >= -16'sd25600, "turn_value outside saturation range")
	`YRPC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "block not busy after an input beat")
	`YRPC_ASSERT_NEXT(a_no_early_result, clk, arst_n, in_valid && !in_stall, !$rose(out_valid), "result appeared right after an input beat")

endmodule

bind yaw_rate_predictive_controller_top yrpc_checker u_yrpc_checker (.*);
